// ===== src/slew_guided_requantizer_unit_assert.svh =====
// Assertion macros shared by the requantizer checker
`ifndef SLEW_GUIDED_REQUANTIZER_UNIT_ASSERT_SVH
`define SLEW_GUIDED_REQUANTIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset
`define SGR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sgr_pkg.sv =====
// Shared constants, types and control struct for the slew guided requantizer
package sgr_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int SCALE_W     = 40;
   localparam int RECIP_W     = 30;
   localparam int DEPTH_W     = 7;
   localparam int HIST_W      = 25;
   localparam int CSR_IDX_W   = 2;

   localparam int MAX_HISTORY  = 98;
   localparam int HIST_ENTRIES = MAX_HISTORY + 1;
   localparam int HIST_AW      = $clog2(HIST_ENTRIES);

   // sample Q1.23 times scale Q24.16 leaves 39 fraction bits
   localparam int QSHIFT     = 39;
   // output: chosen * recip / 2^9, rounded half up
   localparam int OUT_SHIFT  = 9;
   localparam int ROUND_BIAS = 1 << (OUT_SHIFT - 1);

   localparam int HIST_MAX = (1 << (HIST_W - 1)) - 1;
   localparam int HIST_MIN = -(1 << (HIST_W - 1));
   localparam int OUT_MAX  = (1 << (SAMPLE_W - 1)) - 1;
   localparam int OUT_MIN  = -(1 << (SAMPLE_W - 1));

   localparam logic [DEPTH_W-1:0] DEPTH_MIN = DEPTH_W'(3);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_HISTORY);

   localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1) << (SCALE_W - 1);
   localparam logic [RECIP_W-1:0] RECIP_RST = RECIP_W'(512);
   localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_W'(17);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE = 2'd0,
      CSR_RECIP = 2'd1,
      CSR_DEPTH = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_LAST,
      ST_COMMIT
   } sgr_state_type;

   typedef enum logic [1:0] {
      WR_ZERO,
      WR_SHIFT,
      WR_NEW
   } wr_sel_type;

   typedef struct packed {
      logic               ld_x;
      logic               ld_hd;
      logic               commit;
      logic               wr_en;
      wr_sel_type         wr_sel;
      logic [HIST_AW-1:0] wr_addr;
      logic [HIST_AW-1:0] rd_addr;
   } sgr_ctl_type;

endpackage

// ===== src/sgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module sgr_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 99
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sgr_lane.sv =====
// One channel lane: scale, candidate pick, history RAM and output scaling
module sgr_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sgr_pkg::sgr_ctl_type                 ctl,
   input  logic signed [sgr_pkg::SAMPLE_W-1:0]  sample,
   input  logic        [sgr_pkg::SCALE_W-1:0]   scale,
   input  logic        [sgr_pkg::RECIP_W-1:0]   recip,
   input  logic        [sgr_pkg::DEPTH_W-1:0]   depth,
   output logic signed [sgr_pkg::SAMPLE_W-1:0]  result
);
   import sgr_pkg::*;

   localparam int HALF_W = SCALE_W / 2;
   localparam int PP_W   = SAMPLE_W + HALF_W + 1;
   localparam int SUM_W  = SAMPLE_W + SCALE_W + 1;
   localparam int QA_W   = SUM_W - QSHIFT;
   localparam int D1_W   = HIST_W + 2;
   localparam int EA_W   = D1_W + DEPTH_W + 2;
   localparam int YP_W   = HIST_W + RECIP_W + 1;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [PP_W-1:0]     plo_ff, plo_in, phi_ff, phi_in;
   logic signed [QA_W-1:0]     qa_ff, qa_in;
   logic signed [HIST_W-1:0]   hd_ff, hd_in, h0_ff, h0_in, chosen_ff, chosen_in;
   logic signed [YP_W-1:0]     yprod_ff, yprod_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;

   logic signed [HALF_W:0]          slo, shi;
   logic signed [RECIP_W:0]         rsig;
   logic signed [DEPTH_W:0]         dsig;
   logic signed [SUM_W-1:0]         sum;
   logic signed [D1_W-1:0]          diff1, cand;
   logic signed [EA_W-1:0]          ea;
   logic signed [YP_W-1:0]          yt;
   logic                            pick_low;
   logic        [HIST_W-1:0]        rd_data, wr_data;

   always_comb begin
      x_in  = ctl.ld_x ? sample : x_ff;
      hd_in = ctl.ld_hd ? $signed(rd_data) : hd_ff;
      h0_in = ctl.commit ? chosen_ff : h0_ff;

      // 24x40 product split into two 24x21 partial products
      slo    = $signed({1'b0, scale[HALF_W-1:0]});
      shi    = $signed({1'b0, scale[SCALE_W-1:HALF_W]});
      plo_in = PP_W'(x_ff) * PP_W'(slo);
      phi_in = PP_W'(x_ff) * PP_W'(shi);

      // dropping the low QSHIFT bits gives floor toward minus infinity
      sum   = (SUM_W'(phi_ff) <<< HALF_W) + SUM_W'(plo_ff);
      qa_in = sum[SUM_W-1:QSHIFT];

      // ea = d*(h0-q) - (hd-h0); |ea| < |ea-d| reduces to 2*ea < d
      dsig     = $signed({1'b0, depth});
      diff1    = D1_W'(h0_ff) - D1_W'(qa_ff);
      ea       = EA_W'(diff1) * EA_W'(dsig) - (EA_W'(hd_ff) - EA_W'(h0_ff));
      pick_low = (ea <<< 1) < EA_W'(dsig);
      cand     = pick_low ? D1_W'(qa_ff) : D1_W'(qa_ff) + D1_W'(1);
      if (cand > D1_W'(HIST_MAX)) begin
         chosen_in = HIST_W'(HIST_MAX);
      end else if (cand < D1_W'(HIST_MIN)) begin
         chosen_in = HIST_W'(HIST_MIN);
      end else begin
         chosen_in = HIST_W'(cand);
      end

      rsig     = $signed({1'b0, recip});
      yprod_in = YP_W'(chosen_ff) * YP_W'(rsig);

      yt = (yprod_ff + YP_W'(ROUND_BIAS)) >>> OUT_SHIFT;
      if (yt > YP_W'(OUT_MAX)) begin
         y_in = SAMPLE_W'(OUT_MAX);
      end else if (yt < YP_W'(OUT_MIN)) begin
         y_in = SAMPLE_W'(OUT_MIN);
      end else begin
         y_in = SAMPLE_W'(yt);
      end

      case (ctl.wr_sel)
         WR_ZERO:  wr_data = '0;
         WR_SHIFT: wr_data = rd_data;
         WR_NEW:   wr_data = chosen_ff;
         default:  wr_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h0_ff <= '0;
      end else begin
         h0_ff <= h0_in;
      end
      x_ff      <= x_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      qa_ff     <= qa_in;
      hd_ff     <= hd_in;
      chosen_ff <= chosen_in;
      yprod_ff  <= yprod_in;
      y_ff      <= y_in;
   end

   sgr_ram #(
      .WIDTH (HIST_W),
      .DEPTH (HIST_ENTRIES)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_addr),
      .wr_data (wr_data),
      .rd_addr (ctl.rd_addr),
      .rd_data (rd_data)
   );

   assign result = y_ff;

endmodule

// ===== src/sgr_ctrl.sv =====
// Sequencer: history clear sweep, per-item read, in-place shift and commit
module sgr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          out_free,
   input  logic [sgr_pkg::HIST_AW-1:0]   depth_addr,
   input  logic [sgr_pkg::HIST_AW-1:0]   shift_top,
   output logic                          req_stall,
   output sgr_pkg::sgr_ctl_type          ctl
);
   import sgr_pkg::*;

   localparam logic [HIST_AW-1:0] LAST_ENTRY = HIST_AW'(HIST_ENTRIES - 1);

   sgr_state_type      state_ff, state_in;
   logic [HIST_AW-1:0] idx_ff, idx_in;
   logic               first_ff, first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      first_in    = first_ff;
      req_stall   = 1'b1;
      ctl.ld_x    = 1'b0;
      ctl.ld_hd   = 1'b0;
      ctl.commit  = 1'b0;
      ctl.wr_en   = 1'b0;
      ctl.wr_sel  = WR_ZERO;
      ctl.wr_addr = idx_ff;
      ctl.rd_addr = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctl.wr_en = 1'b1;
            if (idx_ff == LAST_ENTRY) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + HIST_AW'(1);
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.ld_x = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // fetch h[d] before the shift touches it
            ctl.rd_addr = depth_addr;
            idx_in      = shift_top - HIST_AW'(1);
            first_in    = 1'b1;
            state_in    = ST_SHIFT;
         end
         ST_SHIFT: begin
            // read entry i-1, write it to entry i once the registered read data returns
            ctl.ld_hd   = first_ff;
            ctl.wr_en   = !first_ff;
            ctl.wr_sel  = WR_SHIFT;
            ctl.wr_addr = idx_ff + HIST_AW'(2);
            first_in    = 1'b0;
            if (idx_ff == '0) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff - HIST_AW'(1);
            end
         end
         ST_LAST: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_sel  = WR_SHIFT;
            ctl.wr_addr = HIST_AW'(1);
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               ctl.commit  = 1'b1;
               ctl.wr_en   = 1'b1;
               ctl.wr_sel  = WR_NEW;
               ctl.wr_addr = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/slew_guided_requantizer_unit.sv =====
// Slew guided stereo requantizer: config registers, two lanes, sequencer, output stage
//
//   channel | ports                                   | direction | handshake
//   --------+-----------------------------------------+-----------+-------------------
//   req     | req_left_sample, req_right_sample       | in        | req_valid/req_stall
//   rsp     | rsp_left_out, rsp_right_out             | out       | rsp_valid/rsp_stall
//   csr     | csr_index, csr_wdata                    | in        | csr_wr_en, no wait
//
// An item occupies the block through its read, shift, last and commit steps; req_stall
// stays high until it is done. The in-place history shift moves entries 0..top-1 up,
// top = min(depth + 1, 98), through each lane's single RAM write port, one history
// entry per cycle. After reset a clearing sweep writes the 99 history entries with
// req_stall high. A stalled result sits in the output register; the next item still
// runs and waits at its commit step until the output register frees up.
module slew_guided_requantizer_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sgr_pkg::SAMPLE_W-1:0]    req_left_sample,
   input  logic signed [sgr_pkg::SAMPLE_W-1:0]    req_right_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sgr_pkg::SAMPLE_W-1:0]    rsp_left_out,
   output logic signed [sgr_pkg::SAMPLE_W-1:0]    rsp_right_out,
   input  logic                                   csr_wr_en,
   input  logic        [sgr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [sgr_pkg::SCALE_W-1:0]     csr_wdata
);
   import sgr_pkg::*;

   // configuration registers
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [RECIP_W-1:0] recip_ff, recip_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   // clamped depth and the top history entry that the shift fills
   logic [DEPTH_W-1:0] depth_eff;
   logic [HIST_AW-1:0] shift_top;

   // output register: merges both lane results into one item
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;
   logic signed [SAMPLE_W-1:0] left_y, right_y;
   logic                       out_free;

   sgr_ctl_type ctl;

   always_comb begin
      scale_in = scale_ff;
      recip_in = recip_ff;
      depth_in = depth_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCALE: scale_in = csr_wdata[SCALE_W-1:0];
            CSR_RECIP: recip_in = csr_wdata[RECIP_W-1:0];
            CSR_DEPTH: depth_in = csr_wdata[DEPTH_W-1:0];
            default:   scale_in = scale_ff;
         endcase
      end
   end

   always_comb begin
      if (depth_ff < DEPTH_MIN) begin
         depth_eff = DEPTH_MIN;
      end else if (depth_ff > DEPTH_MAX) begin
         depth_eff = DEPTH_MAX;
      end else begin
         depth_eff = depth_ff;
      end
      // entries 0..top-1 shift up into 1..top; top never passes the last entry
      if (depth_eff == DEPTH_MAX) begin
         shift_top = HIST_AW'(MAX_HISTORY);
      end else begin
         shift_top = HIST_AW'(depth_eff + DEPTH_W'(1));
      end
   end

   // slot is free when empty or drained this cycle
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = ctl.commit || (rsp_valid_ff && rsp_stall);
      rsp_left_in  = ctl.commit ? left_y : rsp_left_ff;
      rsp_right_in = ctl.commit ? right_y : rsp_right_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RST;
         recip_ff     <= RECIP_RST;
         depth_ff     <= DEPTH_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         recip_ff     <= recip_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   sgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .out_free   (out_free),
      .depth_addr (HIST_AW'(depth_eff)),
      .shift_top  (shift_top),
      .req_stall  (req_stall),
      .ctl        (ctl)
   );

   // both lanes run in lockstep off one control word
   sgr_lane u_left (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_left_sample),
      .scale  (scale_ff),
      .recip  (recip_ff),
      .depth  (depth_eff),
      .result (left_y)
   );

   sgr_lane u_right (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_right_sample),
      .scale  (scale_ff),
      .recip  (recip_ff),
      .depth  (depth_eff),
      .result (right_y)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

// ===== src/sgr_checker.sv =====
// Port-level checker for the requantizer, bound to the top level
`include "slew_guided_requantizer_unit_assert.svh"

module sgr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [23:0] rsp_left_out,
   input logic [23:0] rsp_right_out
);

   `SGR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out), "stalled result changed")

   `SGR_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "second item taken while busy")

   `SGR_ASSERT_SAME(a_result_idle, $rose(rsp_valid), !req_stall, "result posted while still busy")

   `SGR_ASSERT_SAME(a_clear_busy, $past(reset), req_stall, "item taken during history clear")

endmodule

bind slew_guided_requantizer_unit sgr_checker u_sgr_checker (.*);
